// ===== rtl/gcrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GCR record decoder package
// Beat types, queue entry type, register indexes and the two GCR code tables
// with their decode functions.
// ----------------------------------------------------------------------------
package gcrd_pkg;

	// Input beat: one raw disk bit or an end-of-stream flush.
	typedef struct packed {
		logic func;
		logic bit_value;
	} in_t;

	// Output beat.
	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
		logic       record_type;
		logic       bad_code;
		logic       last;
	} out_t;

	// One result as it waits in the queue, before the last flag is known.
	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
		logic       record_type;
		logic       bad_code;
	} rec_t;

	// Queue entry: the one or two results caused by one input beat.
	// When lookup is set, r0 takes its byte from the sector table applied to code.
	typedef struct packed {
		logic        two;
		logic        lookup;
		logic [15:0] code;
		rec_t        r0;
		rec_t        r1;
	} entry_t;

	localparam logic FUNC_BIT   = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic TYPE_SECTOR = 1'b0;
	localparam logic TYPE_DATA   = 1'b1;

	localparam logic REG_SECTOR_SYNC = 1'b0;
	localparam logic REG_DATA_SYNC   = 1'b1;

	localparam logic [31:0] SECTOR_SYNC_RESET = 32'hFFFF_FD57;
	localparam logic [31:0] DATA_SYNC_RESET   = 32'hFFFF_FDDB;

	localparam logic [4:0] SEC_CODE_BITS = 5'd16;
	localparam logic [4:0] DAT_CODE_BITS = 5'd8;

	localparam logic [7:0] BAD_BYTE  = 8'hFF;
	localparam logic [4:0] BAD_GROUP = 5'h1F;

	localparam int SEC_CODES = 78;
	localparam int DAT_CODES = 32;

	localparam logic [15:0] SEC_TAB [SEC_CODES] = '{
		16'hDFB5, 16'h5B6F, 16'h7DF7, 16'hBFD5, 16'hF57F, 16'h6D5D, 16'hAFEB, 16'hDDB7,
		16'h5775, 16'h7BFB, 16'hBDD7, 16'hEFAB, 16'h6B5F, 16'hADED, 16'hDBBB, 16'h5577,
		16'h77DB, 16'hBBAD, 16'hED6B, 16'h5FEF, 16'hABBD, 16'hD77B, 16'hFB57, 16'h75DD,
		16'hB7AF, 16'hEB6D, 16'h5DF5, 16'h7FBF, 16'hD57D, 16'hF75B, 16'h6FDF, 16'hB5B5,
		16'hDF6F, 16'h5BF7, 16'h7DD5, 16'hBF7F, 16'hF55D, 16'h6DEB, 16'hAFB7, 16'hDD75,
		16'h57FB, 16'h7BD7, 16'hBDAB, 16'hEF5F, 16'h6BED, 16'hADBB, 16'hDB77, 16'hBB55,
		16'hEDDB, 16'h5FAD, 16'hAB6B, 16'hD7EF, 16'hFBBD, 16'h757B, 16'hB757, 16'hEBDD,
		16'h5DAF, 16'h7F6D, 16'hD5F5, 16'hF7BF, 16'h6F7D, 16'hB55B, 16'hDFDF, 16'h5BB5,
		16'h7D6F, 16'hBFF7, 16'hF5D5, 16'h6D7F, 16'hAF5D, 16'hDDEB, 16'h57B7, 16'h7B75,
		16'hBDFB, 16'hEFD7, 16'h6BAB, 16'hAD5F, 16'hDBED, 16'h55BB
	};

	localparam logic [7:0] DAT_TAB [DAT_CODES] = '{
		8'h55, 8'h57, 8'h5b, 8'h5d, 8'h5f, 8'h6b, 8'h6d, 8'h6f,
		8'h75, 8'h77, 8'h7b, 8'h7d, 8'h7f, 8'hab, 8'had, 8'haf,
		8'hb5, 8'hb7, 8'hbb, 8'hbd, 8'hbf, 8'hd5, 8'hd7, 8'hdb,
		8'hdd, 8'hdf, 8'heb, 8'hed, 8'hef, 8'hf5, 8'hf7, 8'hfb
	};

	// Sector code word to byte. Result is {bad, byte}.
	function automatic logic [8:0] sec_decode(input logic [15:0] word);
		logic [8:0] res;
		res = {1'b1, BAD_BYTE};
		for (int i = 0; i < SEC_CODES; i++) begin
			if (SEC_TAB[i] == word) begin
				res = {1'b0, 8'(i)};
			end
		end
		return res;
	endfunction

	// Data code word to 5-bit group. Result is {bad, group}.
	function automatic logic [5:0] dat_decode(input logic [7:0] word);
		logic [5:0] res;
		res = {1'b1, BAD_GROUP};
		for (int i = 0; i < DAT_CODES; i++) begin
			if (DAT_TAB[i] == word) begin
				res = {1'b0, 5'(i)};
			end
		end
		return res;
	endfunction

endpackage

// ===== rtl/gcrd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GCR record decoder front end
// Shifts raw bits into the window, detects sync words, counts code bits,
// decodes and packs data groups, and queues the results of each beat.
// ----------------------------------------------------------------------------
module gcrd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  gcrd_pkg::in_t    in_data,
	output logic             in_stall,
	input  logic [31:0]      sector_sync,
	input  logic [31:0]      data_sync,
	input  logic             q_full,
	output logic             push,
	output gcrd_pkg::entry_t push_entry
);

	typedef enum logic [1:0] {
		MODE_SEEK,
		MODE_SECTOR,
		MODE_DATA
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [31:0] win_q, win_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [7:0]  acc_q, acc_d;
	logic [2:0]  pbc_q, pbc_d;
	logic        pbad_q, pbad_d;

	logic            accept;
	logic [31:0]     win_n;
	logic            is_sec;
	logic            is_dat;
	logic            open_rec;
	gcrd_pkg::rec_t  end_rec;
	gcrd_pkg::rec_t  first_rec;
	logic [5:0]      dat_res;
	logic [12:0]     combined;
	logic [2:0]      sh;
	logic [12:0]     comb_sh;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign win_n    = {win_q[30:0], in_data.bit_value};
	assign is_sec   = (win_n == sector_sync);
	assign is_dat   = (win_n == data_sync);
	assign open_rec = (mode_q == MODE_SECTOR) || (mode_q == MODE_DATA);
	assign dat_res  = gcrd_pkg::dat_decode(win_n[7:0]);
	assign combined = {acc_q, dat_res[4:0]};
	assign sh       = pbc_q - 3'd3;
	assign comb_sh  = combined >> sh;

	always_comb begin
		end_rec.kind        = gcrd_pkg::KIND_END;
		end_rec.byte_value  = 8'h00;
		end_rec.record_type = (mode_q == MODE_DATA) ? gcrd_pkg::TYPE_DATA
		                                            : gcrd_pkg::TYPE_SECTOR;
		end_rec.bad_code    = 1'b0;

		first_rec.kind        = gcrd_pkg::KIND_BYTE;
		first_rec.byte_value  = win_n[7:0];
		first_rec.record_type = is_sec ? gcrd_pkg::TYPE_SECTOR : gcrd_pkg::TYPE_DATA;
		first_rec.bad_code    = 1'b0;
	end

	always_comb begin
		mode_d     = mode_q;
		win_d      = win_q;
		cnt_d      = cnt_q;
		acc_d      = acc_q;
		pbc_d      = pbc_q;
		pbad_d     = pbad_q;
		push       = 1'b0;
		push_entry = '0;
		if (accept) begin
			if (in_data.func == gcrd_pkg::FUNC_FLUSH) begin
				push          = open_rec;
				push_entry.r0 = end_rec;
				mode_d        = MODE_SEEK;
				win_d         = '0;
				cnt_d         = '0;
				acc_d         = '0;
				pbc_d         = '0;
				pbad_d        = 1'b0;
			end else begin
				win_d = win_n;
				if (is_sec || is_dat) begin
					// A sync word closes any open record, then opens the new one.
					push           = 1'b1;
					push_entry.two = open_rec;
					push_entry.r0  = open_rec ? end_rec : first_rec;
					push_entry.r1  = first_rec;
					cnt_d          = '0;
					if (is_sec) begin
						mode_d = MODE_SECTOR;
					end else begin
						mode_d = MODE_DATA;
						pbc_d  = '0;
						pbad_d = 1'b0;
					end
				end else begin
					case (mode_q)
						MODE_SECTOR: begin
							if (cnt_q == gcrd_pkg::SEC_CODE_BITS - 5'd1) begin
								push                      = 1'b1;
								push_entry.lookup         = 1'b1;
								push_entry.code           = win_n[15:0];
								push_entry.r0.kind        = gcrd_pkg::KIND_BYTE;
								push_entry.r0.record_type = gcrd_pkg::TYPE_SECTOR;
								cnt_d                     = '0;
							end else begin
								cnt_d = cnt_q + 5'd1;
							end
						end
						MODE_DATA: begin
							if (cnt_q == gcrd_pkg::DAT_CODE_BITS - 5'd1) begin
								cnt_d = '0;
								acc_d = combined[7:0];
								// Five group bits complete a byte when three or more
								// bits are already waiting in the accumulator.
								if (pbc_q >= 3'd3) begin
									push                      = 1'b1;
									push_entry.r0.kind        = gcrd_pkg::KIND_BYTE;
									push_entry.r0.byte_value  = comb_sh[7:0];
									push_entry.r0.record_type = gcrd_pkg::TYPE_DATA;
									push_entry.r0.bad_code    = pbad_q || dat_res[5];
									pbc_d                     = sh;
									pbad_d                    = (pbc_q != 3'd3) && dat_res[5];
								end else begin
									pbc_d  = pbc_q + 3'd5;
									pbad_d = pbad_q || dat_res[5];
								end
							end else begin
								cnt_d = cnt_q + 5'd1;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SEEK;
			win_q  <= '0;
			cnt_q  <= '0;
			acc_q  <= '0;
			pbc_q  <= '0;
			pbad_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			win_q  <= win_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			pbc_q  <= pbc_d;
			pbad_q <= pbad_d;
		end
	end

endmodule

// ===== rtl/gcrd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GCR record decoder queue
// Small FIFO of result entries between the front end and the back end.
// ----------------------------------------------------------------------------
module gcrd_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gcrd_pkg::entry_t push_entry,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output gcrd_pkg::entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gcrd_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/gcrd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GCR record decoder back end
// Finishes sector byte lookups and sends queued results, one per beat,
// through an output register.
// ----------------------------------------------------------------------------
module gcrd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  gcrd_pkg::entry_t head,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output gcrd_pkg::out_t   out_data
);

	logic            phase_q;
	logic            out_valid_q;
	gcrd_pkg::out_t  out_q;
	logic [8:0]      dec;
	gcrd_pkg::rec_t  rec;
	logic            is_last;
	logic            load;

	assign dec     = gcrd_pkg::sec_decode(head.code);
	assign is_last = !head.two || phase_q;
	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign pop     = load && is_last;

	always_comb begin
		rec = phase_q ? head.r1 : head.r0;
		if (!phase_q && head.lookup) begin
			rec.byte_value = dec[7:0];
			rec.bad_code   = dec[8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= !is_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.kind        <= rec.kind;
			out_q.byte_value  <= rec.byte_value;
			out_q.record_type <= rec.record_type;
			out_q.bad_code    <= rec.bad_code;
			out_q.last        <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_phase_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (head_valid && head.two))
		else $error("second result pending without a two-result entry");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !phase_q && head.two) |=> phase_q)
		else $error("second result of an entry was skipped");

	a_end_marker_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == gcrd_pkg::KIND_END)
		|-> (out_q.byte_value == 8'h00 && !out_q.bad_code))
		else $error("end marker carries a byte or bad flag");

endmodule

// ===== rtl/gcr_record_bit_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GCR record bit decoder
// Turns a raw disk bitstream into framed sector header and data records.
// ----------------------------------------------------------------------------
// The block accepts one input beat per cycle unless stalled: a raw disk bit or an
// end-of-stream flush. A front end shifts each bit into a 32-bit window,
// matches the window against the two sync registers, counts code bits and
// decodes and packs data groups in the same cycle, so the input side runs at
// one beat per cycle while the queue is not full. The results of each input
// beat go into a queue of QUEUE_DEPTH entries; a back end translates sector
// code words through the 78-entry table and sends one output beat per cycle,
// unless out_stall holds it, from its output register. An input beat causes
// zero, one or two results; two (an end marker and the first byte of a new
// record) only at a sync match while a record is open, so the output side
// sends two output beats for such an input beat and the queue absorbs that.
// in_stall rises only while the queue is full. The last field marks the
// final output beat caused by an input beat. Registers: sector sync at byte
// address 0, data sync at byte address 4, written through the APB port.
// ----------------------------------------------------------------------------
module gcr_record_bit_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,

	input  logic           in_valid,
	output logic           in_stall,
	input  gcrd_pkg::in_t  in_data,

	output logic           out_valid,
	input  logic           out_stall,
	output gcrd_pkg::out_t out_data,

	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	logic [31:0] sector_sync_q;
	logic [31:0] data_sync_q;
	logic        cfg_write;
	logic        reg_sel;

	logic             push;
	gcrd_pkg::entry_t push_entry;
	logic             pop;
	logic             q_full;
	logic             head_valid;
	gcrd_pkg::entry_t head;

	// Configuration port. Writes complete in the access phase; the port never
	// inserts wait states. Bit 2 of the byte address picks the register.
	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (reg_sel == gcrd_pkg::REG_DATA_SYNC) ? data_sync_q : sector_sync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_sync_q <= gcrd_pkg::SECTOR_SYNC_RESET;
			data_sync_q   <= gcrd_pkg::DATA_SYNC_RESET;
		end else if (cfg_write) begin
			if (reg_sel == gcrd_pkg::REG_DATA_SYNC) begin
				data_sync_q <= pwdata;
			end else begin
				sector_sync_q <= pwdata;
			end
		end
	end

	// Front end: window, sync detection, bit counting and data group packing.
	gcrd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.in_stall   (in_stall),
		.sector_sync(sector_sync_q),
		.data_sync  (data_sync_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue of pending results, one entry per input beat that has any.
	gcrd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head)
	);

	// Back end: sector table lookup and the output register.
	gcrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
